// ----- hdl/stpk_pkg.sv -----
// Shared types, constants and helpers for the stereo half side-by-side / top-bottom packer.
`timescale 1ns / 1ps
package stpk_pkg;

  // Size register width, its one-bit-wider compare width, sample and coordinate widths
  localparam int SZW = 13;
  localparam int EW  = SZW + 1;
  localparam int SW  = 8;
  localparam int DW  = 12;
  localparam int CIW = 2;

  // Register reset values for the plane size
  localparam int WIDTH_RESET  = 1920;
  localparam int HEIGHT_RESET = 1080;

  typedef enum logic [CIW-1:0] {
    CFG_PACK_MODE    = 2'd0,
    CFG_PLANE_WIDTH  = 2'd1,
    CFG_PLANE_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_SBS = 1'b0,
    MODE_TAB = 1'b1
  } pack_mode_e;

  // Per-item control, worked out when the beat is accepted
  typedef struct packed {
    logic          tb;
    logic          carry;
    logic          emit;
    logic          done;
    logic [DW-1:0] x0;
    logic [DW-1:0] y0;
    logic [DW-1:0] x1;
    logic [DW-1:0] y1;
  } item_t;

  typedef struct packed {
    logic tb;
    logic carry;
  } lane_ctl_t;

  typedef struct packed {
    logic [SW-1:0] value;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic          done;
  } result_t;

  // Clamp a size to [2, hi]
  function automatic logic [SZW-1:0] clamp_size(input logic [SZW-1:0] v,
                                                input logic [SZW:0] hi);
    logic [SZW-1:0] r;
    if (v < SZW'(2)) begin
      r = SZW'(2);
    end else if ({1'b0, v} > hi) begin
      r = hi[SZW-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/stpk_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module stpk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/stpk_raster.sv -----
// Configuration registers, raster counters and destination address generation.
`timescale 1ns / 1ps
module stpk_raster #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stpk_pkg::CIW-1:0]        cfg_idx_i,
  input  logic [stpk_pkg::SZW-1:0]        cfg_data_i,
  input  logic                            step_i,
  output stpk_pkg::item_t                 item_o,
  output logic                            hold_o,
  output logic                            store_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    store_addr_o
);
  import stpk_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam logic [SZW:0]   MaxW = EW'(MAX_WIDTH);
  localparam logic [SZW:0]   MaxH = EW'(MAX_HEIGHT);
  localparam logic [SZW-1:0] WRst = clamp_size(SZW'(WIDTH_RESET), MaxW);
  localparam logic [SZW-1:0] HRst = clamp_size(SZW'(HEIGHT_RESET), MaxH);

  logic           mode_q;
  logic [SZW-1:0] w_q, h_q;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;

  logic           wrap;
  logic [CW-1:0]  x;
  logic [RW:0]    ry;
  logic [RW-1:0]  y;
  logic [CW:0]    xn;
  logic [RW:0]    yn;
  logic           col_end, row_end;
  logic [SZW-1:0] x_ext, y_ext, half_w, half_h, x_half, y_half;
  logic           x_last;
  logic [SZW-1:0] x0_w, y0_w, x1_w, y1_w;

  // Hold configuration, clamping the sizes as they are written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SBS;
      w_q    <= WRst;
      h_q    <= HRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PACK_MODE:    mode_q <= cfg_data_i[0];
        CFG_PLANE_WIDTH:  w_q    <= clamp_size(cfg_data_i, MaxW);
        CFG_PLANE_HEIGHT: h_q    <= clamp_size(cfg_data_i, MaxH);
        default:          ;
      endcase
    end
  end

  // Position of this beat, moving on first if the size shrank under the counters
  always_comb begin
    wrap   = EW'(col_q) >= EW'(w_q);
    x      = wrap ? '0 : col_q;
    ry     = wrap ? ({1'b0, row_q} + (RW+1)'(1)) : {1'b0, row_q};
    y      = (EW'(ry) >= EW'(h_q)) ? '0 : ry[RW-1:0];
    xn     = {1'b0, x} + (CW+1)'(1);
    yn     = {1'b0, y} + (RW+1)'(1);
    col_end = EW'(xn) >= EW'(w_q);
    row_end = EW'(yn) >= EW'(h_q);
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : yn[RW-1:0];
    end else begin
      col_d = xn[CW-1:0];
      row_d = y;
    end
  end

  // Advance the raster on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Destination coordinates and flags for both eyes
  always_comb begin
    x_ext  = SZW'(x);
    y_ext  = SZW'(y);
    half_w = w_q >> 1;
    half_h = h_q >> 1;
    x_half = x_ext >> 1;
    y_half = y_ext >> 1;
    x_last = x_ext == (w_q - SZW'(1));
    item_o = '0;
    x0_w   = '0;
    y0_w   = '0;
    x1_w   = '0;
    y1_w   = '0;
    if (mode_q == MODE_SBS) begin
      item_o.tb   = 1'b0;
      item_o.done = (y_ext == (h_q - SZW'(1))) && x_last;
      y0_w        = y_ext;
      y1_w        = y_ext;
      if (x[0]) begin
        item_o.emit = 1'b1;
        x0_w        = x_half;
        x1_w        = half_w + x_half;
      end else begin
        item_o.emit  = x_last;
        item_o.carry = 1'b1;
        x0_w         = half_w - SZW'(1);
        x1_w         = half_w + half_w - SZW'(1);
      end
    end else begin
      item_o.tb   = 1'b1;
      item_o.emit = y[0];
      item_o.done = (y_ext == (half_h + half_h - SZW'(1))) && x_last;
      x0_w        = x_ext;
      x1_w        = x_ext;
      y0_w        = y_half;
      y1_w        = half_h + y_half;
    end
    item_o.x0 = x0_w[DW-1:0];
    item_o.y0 = y0_w[DW-1:0];
    item_o.x1 = x1_w[DW-1:0];
    item_o.y1 = y1_w[DW-1:0];
  end

  assign hold_o       = step_i && (mode_q == MODE_SBS) && !x[0];
  assign store_we_o   = step_i && (mode_q == MODE_TAB) && !y[0];
  assign store_addr_o = x;

endmodule

// ----- hdl/stpk_lane.sv -----
// One eye's lane: held sample and rounded pair average.
`timescale 1ns / 1ps
module stpk_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     hold_en_i,
  input  logic [stpk_pkg::SW-1:0]  hold_sample_i,
  input  logic [stpk_pkg::SW-1:0]  sample_i,
  input  logic [stpk_pkg::SW-1:0]  store_sample_i,
  input  stpk_pkg::lane_ctl_t      ctl_i,
  output logic [stpk_pkg::SW-1:0]  value_o
);
  import stpk_pkg::*;

  logic [SW-1:0] held_q;
  logic [SW-1:0] partner;
  logic [SW:0]   sum;

  // Hold the even-column sample for side-by-side averaging
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (hold_en_i) begin
      held_q <= hold_sample_i;
    end
  end

  // Average with rounding, or pass the sample through for the unpaired column
  always_comb begin
    partner = ctl_i.tb ? store_sample_i : held_q;
    sum     = {1'b0, partner} + {1'b0, sample_i} + (SW+1)'(1);
    value_o = ctl_i.carry ? sample_i : sum[SW:1];
  end

endmodule

// ----- hdl/stpk_merge.sv -----
// Merge stage: takes both lane results and sends them out one beat at a time.
`timescale 1ns / 1ps
module stpk_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s1_valid_i,
  input  logic                     s1_emit_i,
  input  stpk_pkg::result_t        res0_i,
  input  stpk_pkg::result_t        res1_i,
  output logic                     s1_go_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [stpk_pkg::SW-1:0]  packed_value_o,
  output logic [stpk_pkg::DW-1:0]  dest_x_o,
  output logic [stpk_pkg::DW-1:0]  dest_y_o,
  output logic                     last_of_run_o,
  output logic                     plane_done_o
);
  import stpk_pkg::*;

  logic    full_q, sel_q;
  result_t res0_q, res1_q, cur;
  logic    load_ok, load;

  assign load_ok = !full_q || (sel_q && !out_stall_i);
  assign s1_go_o = !s1_emit_i || load_ok;
  assign load    = s1_valid_i && s1_emit_i && load_ok;

  // Track which of the pair is on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      sel_q  <= 1'b0;
    end else if (load) begin
      full_q <= 1'b1;
      sel_q  <= 1'b0;
    end else if (full_q && !out_stall_i) begin
      if (sel_q) begin
        full_q <= 1'b0;
      end
      sel_q <= !sel_q;
    end
  end

  // Capture the pair
  always_ff @(posedge clk_i) begin
    if (load) begin
      res0_q <= res0_i;
      res1_q <= res1_i;
    end
  end

  assign cur            = sel_q ? res1_q : res0_q;
  assign out_valid_o    = full_q;
  assign packed_value_o = cur.value;
  assign dest_x_o       = cur.x;
  assign dest_y_o       = cur.y;
  assign last_of_run_o  = sel_q;
  assign plane_done_o   = sel_q && cur.done;

endmodule

// ----- hdl/stereo_half_sbs_tab_packer.sv -----
// Top level of the stereo half side-by-side / top-bottom packer.
// Pipeline: the beat is registered in the lane stage and its pair in the merge stage;
// the first result goes out before the second. Throughput: 1 beat per cycle for beats
// with no result while not stalled; a pair waits for the single-result output channel.
// Reset: counters, held samples and registers cleared to their reset values at
// once; the line store is not cleared and needs no start-up pass.
`timescale 1ns / 1ps
module stereo_half_sbs_tab_packer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [stpk_pkg::CIW-1:0] cfg_idx_i,
  input  logic [stpk_pkg::SZW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [stpk_pkg::SW-1:0]  left_sample_i,
  input  logic [stpk_pkg::SW-1:0]  right_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [stpk_pkg::SW-1:0]  packed_value_o,
  output logic [stpk_pkg::DW-1:0]  dest_x_o,
  output logic [stpk_pkg::DW-1:0]  dest_y_o,
  output logic                     last_of_run_o,
  output logic                     plane_done_o
);
  import stpk_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic              accept;
  item_t             item;
  logic              hold, store_we;
  logic [CW-1:0]     store_addr;
  logic [2*SW-1:0]   store_rdata;

  logic              s1_valid_q;
  item_t             s1_item_q;
  logic [SW-1:0]     s1_left_q, s1_right_q;
  logic              s1_go;
  lane_ctl_t         lane_ctl;
  logic [SW-1:0]     left_value, right_value;
  result_t           res0, res1;

  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  stpk_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .step_i       (accept),
    .item_o       (item),
    .hold_o       (hold),
    .store_we_o   (store_we),
    .store_addr_o (store_addr)
  );

  // Line store: left eye in the low byte, right eye in the high byte
  stpk_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_addr),
    .wdata_i ({right_sample_i, left_sample_i}),
    .re_i    (accept),
    .raddr_i (store_addr),
    .rdata_o (store_rdata)
  );

  // Lane stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= item;
      s1_left_q  <= left_sample_i;
      s1_right_q <= right_sample_i;
    end
  end

  assign lane_ctl = '{tb: s1_item_q.tb, carry: s1_item_q.carry};

  stpk_lane u_lane_left (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hold_en_i      (hold),
    .hold_sample_i  (left_sample_i),
    .sample_i       (s1_left_q),
    .store_sample_i (store_rdata[SW-1:0]),
    .ctl_i          (lane_ctl),
    .value_o        (left_value)
  );

  stpk_lane u_lane_right (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hold_en_i      (hold),
    .hold_sample_i  (right_sample_i),
    .sample_i       (s1_right_q),
    .store_sample_i (store_rdata[2*SW-1:SW]),
    .ctl_i          (lane_ctl),
    .value_o        (right_value)
  );

  // Pair the lane results with their destinations
  assign res0 = '{value: left_value, x: s1_item_q.x0, y: s1_item_q.y0, done: 1'b0};
  assign res1 = '{value: right_value, x: s1_item_q.x1, y: s1_item_q.y1,
                  done: s1_item_q.done};

  stpk_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_valid_i     (s1_valid_q),
    .s1_emit_i      (s1_item_q.emit),
    .res0_i         (res0),
    .res1_i         (res1),
    .s1_go_o        (s1_go),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_value_o (packed_value_o),
    .dest_x_o       (dest_x_o),
    .dest_y_o       (dest_y_o),
    .last_of_run_o  (last_of_run_o),
    .plane_done_o   (plane_done_o)
  );

endmodule
